// File: rtl/core/max_pooling_with_argmax_unit_assert.svh
// ---------------------------------------------------------------------------
// Max pooling with argmax: assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef MAX_POOLING_WITH_ARGMAX_UNIT_ASSERT_SVH
`define MAX_POOLING_WITH_ARGMAX_UNIT_ASSERT_SVH

// property must hold at every edge
`define MPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mpa_pkg.sv
// ---------------------------------------------------------------------------
// mpa_pkg
// Types, sizes and register codes of the max pooling with argmax unit.
// ---------------------------------------------------------------------------
package mpa_pkg;

  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned MaxHeight   = 1024;
  localparam int unsigned MaxChannels = 16;
  localparam int unsigned MaxWindow   = 8;

  // register and stream field widths
  localparam int unsigned DimW     = 11;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned WinW     = 4;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned IndexW   = 24;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  // position counters
  localparam int unsigned ColW   = $clog2(MaxWidth);
  localparam int unsigned RowW   = $clog2(MaxHeight);
  localparam int unsigned PlaneW = $clog2(MaxChannels);
  localparam int unsigned RemW   = $clog2(MaxWindow);

  // divide by window side: multiply by ceil(2^16 / k), take the upper bits
  localparam int unsigned RecipShift = 16;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned DivDimW    = DimW + RecipW;
  localparam int unsigned DivColW    = ColW + RecipW;
  localparam int unsigned DivRowW    = RowW + RecipW;
  localparam int unsigned BackColW   = ColW + WinW;
  localparam int unsigned BackRowW   = RowW + WinW;

  // flat index products
  localparam int unsigned PhW  = PlaneW + DimW;
  localparam int unsigned PhwW = PhW + DimW;
  localparam int unsigned YwW  = RowW + DimW;

  // result queue
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);
  localparam int unsigned OccW      = FifoCntW + 1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgImageWidth   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgChannelCount = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWindowSize   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFloorValue   = 3'd4;

  // reset values
  localparam logic [DimW-1:0]           RstImageWidth   = 11'd32;
  localparam logic [DimW-1:0]           RstImageHeight  = 11'd32;
  localparam logic [ChanW-1:0]          RstChannelCount = 5'd1;
  localparam logic [WinW-1:0]           RstWindowSize   = 4'd2;
  localparam logic signed [SampleW-1:0] RstFloorValue   = -16'sd31968;

  typedef struct packed {
    logic signed [SampleW-1:0] value;
    logic [IndexW-1:0]         index;
    logic                      valid;
  } best_t;

  typedef struct packed {
    logic signed [SampleW-1:0] max_value;
    logic [IndexW-1:0]         max_index;
    logic                      index_valid;
    logic                      frame_last;
  } result_t;

  function automatic logic [RecipW-1:0] window_recip(input logic [WinW-1:0] k);
    logic [RecipW-1:0] r;
    unique case (k)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/max_pooling_with_argmax_unit.sv
// ---------------------------------------------------------------------------
// max_pooling_with_argmax_unit
// Square-window max pooling with argmax over a planar raster sample stream.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed Q10.5 sample per request, plane by plane, row by
//   row, column by column. m_axis carries one request per completed window:
//   maximum, flat index of the first maximum, index-valid flag in tuser and
//   the frame's final result marked by tlast.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i while the
//   block is idle; zero reads as one, oversized values saturate.
//   Throughput: one sample per cycle while s_axis_tready is high. The result
//   of a window passes through the pipeline stages and the result queue to m_axis.
//   The running best of each window column sits in a 1024-entry memory,
//   read in stage 3 and written back in stage 4, with one-deep forwarding.
//   A stalled receiver fills an 8-entry result queue; s_axis_tready drops
//   once queued plus in-flight requests reach 8, so nothing is lost.
//   Reset restores the register defaults, clears the position counters, the
//   pipeline and the queue; memory contents are not cleared, as every window
//   entry is restarted by the first sample of its window.
// ---------------------------------------------------------------------------
module max_pooling_with_argmax_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [15:0] max_value, [39:16] max_index
  output logic        m_axis_tuser,  // [0] index_valid
  output logic        m_axis_tlast
);

  // configuration
  logic [mpa_pkg::DimW-1:0]           img_w_q, img_h_q;
  logic [mpa_pkg::ChanW-1:0]          chan_q;
  logic [mpa_pkg::WinW-1:0]           win_q;
  logic signed [mpa_pkg::SampleW-1:0] floor_q;

  logic [mpa_pkg::DimW-1:0]   w_c, h_c;
  logic [mpa_pkg::ChanW-1:0]  c_c;
  logic [mpa_pkg::WinW-1:0]   k_c, k_m1;
  logic [mpa_pkg::RecipW-1:0] recip_k;
  logic [mpa_pkg::DivDimW-1:0] wdiv, hdiv;
  logic [mpa_pkg::DimW-1:0]   cols_q, rows_q, cols_m1, rows_m1;

  // position counters
  logic [mpa_pkg::ColW-1:0]   col_q, col_d;
  logic [mpa_pkg::RowW-1:0]   row_q, row_d;
  logic [mpa_pkg::PlaneW-1:0] plane_q, plane_d;
  logic [mpa_pkg::DimW-1:0]   col_ext, row_ext;
  logic [mpa_pkg::DimW-1:0]   x_inc, y_inc;
  logic [mpa_pkg::ChanW-1:0]  p_inc;
  logic                       s_fire;

  // pipeline
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [mpa_pkg::SampleW-1:0] smp1_q, smp2_q, smp3_q, smp4_q;
  logic [mpa_pkg::ColW-1:0]   x1_q, x2_q, x3_q;
  logic [mpa_pkg::RowW-1:0]   y1_q, y2_q;
  logic [mpa_pkg::PlaneW-1:0] p1_q, p2_q;

  logic [mpa_pkg::DivColW-1:0] xprod;
  logic [mpa_pkg::DivRowW-1:0] yprod;
  logic [mpa_pkg::PhW-1:0]     ph, ph2_q;
  logic [mpa_pkg::YwW-1:0]     yw, yw2_q;
  logic [mpa_pkg::ColW-1:0]    xq2_q, slot3_q, slot4_q;
  logic [mpa_pkg::RowW-1:0]    yq2_q;

  logic [mpa_pkg::BackColW-1:0] xqk;
  logic [mpa_pkg::BackRowW-1:0] yqk;
  logic [mpa_pkg::ColW-1:0]     dx_full;
  logic [mpa_pkg::RowW-1:0]     dy_full;
  logic [mpa_pkg::PhwW-1:0]     phw;
  logic [mpa_pkg::DimW-1:0]     xq2_ext, yq2_ext;
  logic [mpa_pkg::ChanW-1:0]    p2_ext;
  logic                         in2, last2;

  logic [mpa_pkg::RemW-1:0]   dx3_q, dy3_q;
  logic [mpa_pkg::IndexW-1:0] phw3_q, yw3_q, idx3, idx4_q;
  logic in3_q, last3_q, start3, fin3;
  logic in4_q, last4_q, start4_q, fin4_q;

  // window memory
  mpa_pkg::best_t mem_q [mpa_pkg::MaxWidth];
  mpa_pkg::best_t rd_q, fwd_q, src, base, upd;
  logic [mpa_pkg::ColW-1:0] fwd_slot_q;
  logic fwd_v_q, beat, wr_en;

  // result queue
  mpa_pkg::result_t fifo_q [mpa_pkg::FifoDepth];
  mpa_pkg::result_t res, head;
  logic [mpa_pkg::FifoPtrW-1:0] wp_q, rp_q;
  logic [mpa_pkg::FifoCntW-1:0] cnt_q;
  logic [mpa_pkg::OccW-1:0]     occ;
  logic push, pop;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= mpa_pkg::RstImageWidth;
      img_h_q <= mpa_pkg::RstImageHeight;
      chan_q  <= mpa_pkg::RstChannelCount;
      win_q   <= mpa_pkg::RstWindowSize;
      floor_q <= mpa_pkg::RstFloorValue;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mpa_pkg::CfgImageWidth:   img_w_q <= cfg_data_i[mpa_pkg::DimW-1:0];
        mpa_pkg::CfgImageHeight:  img_h_q <= cfg_data_i[mpa_pkg::DimW-1:0];
        mpa_pkg::CfgChannelCount: chan_q  <= cfg_data_i[mpa_pkg::ChanW-1:0];
        mpa_pkg::CfgWindowSize:   win_q   <= cfg_data_i[mpa_pkg::WinW-1:0];
        mpa_pkg::CfgFloorValue:   floor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c = (img_w_q == '0) ? mpa_pkg::DimW'(1) :
          (img_w_q > mpa_pkg::DimW'(mpa_pkg::MaxWidth)) ?
          mpa_pkg::DimW'(mpa_pkg::MaxWidth) : img_w_q;
    h_c = (img_h_q == '0) ? mpa_pkg::DimW'(1) :
          (img_h_q > mpa_pkg::DimW'(mpa_pkg::MaxHeight)) ?
          mpa_pkg::DimW'(mpa_pkg::MaxHeight) : img_h_q;
    c_c = (chan_q == '0) ? mpa_pkg::ChanW'(1) :
          (chan_q > mpa_pkg::ChanW'(mpa_pkg::MaxChannels)) ?
          mpa_pkg::ChanW'(mpa_pkg::MaxChannels) : chan_q;
    k_c = (win_q == '0) ? mpa_pkg::WinW'(1) :
          (win_q > mpa_pkg::WinW'(mpa_pkg::MaxWindow)) ?
          mpa_pkg::WinW'(mpa_pkg::MaxWindow) : win_q;
  end

  assign k_m1    = k_c - mpa_pkg::WinW'(1);
  assign recip_k = mpa_pkg::window_recip(k_c);
  assign wdiv    = mpa_pkg::DivDimW'(w_c) * mpa_pkg::DivDimW'(recip_k);
  assign hdiv    = mpa_pkg::DivDimW'(h_c) * mpa_pkg::DivDimW'(recip_k);
  assign cols_m1 = cols_q - mpa_pkg::DimW'(1);
  assign rows_m1 = rows_q - mpa_pkg::DimW'(1);

  // whole windows per row and per column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= '0;
      rows_q <= '0;
    end else begin
      cols_q <= wdiv[mpa_pkg::RecipShift +: mpa_pkg::DimW];
      rows_q <= hdiv[mpa_pkg::RecipShift +: mpa_pkg::DimW];
    end
  end

  // ---- position counters ----
  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign col_ext = mpa_pkg::DimW'(col_q);
  assign row_ext = mpa_pkg::DimW'(row_q);
  assign x_inc   = col_ext + mpa_pkg::DimW'(1);
  assign y_inc   = row_ext + mpa_pkg::DimW'(1);
  assign p_inc   = mpa_pkg::ChanW'(plane_q) + mpa_pkg::ChanW'(1);

  always_comb begin
    col_d   = x_inc[mpa_pkg::ColW-1:0];
    row_d   = row_q;
    plane_d = plane_q;
    if (x_inc >= w_c) begin
      col_d = '0;
      row_d = y_inc[mpa_pkg::RowW-1:0];
      if (y_inc >= h_c) begin
        row_d   = '0;
        plane_d = (p_inc >= c_c) ? '0 : p_inc[mpa_pkg::PlaneW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      plane_q <= '0;
    end else if (s_fire) begin
      col_q   <= col_d;
      row_q   <= row_d;
      plane_q <= plane_d;
    end
  end

  // ---- pipeline control ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      fwd_v_q <= 1'b0;
    end else begin
      v1_q    <= s_fire;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      fwd_v_q <= wr_en;
    end
  end

  // stage 1: window column/row and index products
  assign xprod = mpa_pkg::DivColW'(x1_q) * mpa_pkg::DivColW'(recip_k);
  assign yprod = mpa_pkg::DivRowW'(y1_q) * mpa_pkg::DivRowW'(recip_k);
  assign ph    = mpa_pkg::PhW'(p1_q) * mpa_pkg::PhW'(h_c);
  assign yw    = mpa_pkg::YwW'(y1_q) * mpa_pkg::YwW'(w_c);

  // stage 2: offsets within the window, range and frame end
  assign xqk     = mpa_pkg::BackColW'(xq2_q) * mpa_pkg::BackColW'(k_c);
  assign yqk     = mpa_pkg::BackRowW'(yq2_q) * mpa_pkg::BackRowW'(k_c);
  assign dx_full = x2_q - xqk[mpa_pkg::ColW-1:0];
  assign dy_full = y2_q - yqk[mpa_pkg::RowW-1:0];
  assign phw     = mpa_pkg::PhwW'(ph2_q) * mpa_pkg::PhwW'(w_c);
  assign xq2_ext = mpa_pkg::DimW'(xq2_q);
  assign yq2_ext = mpa_pkg::DimW'(yq2_q);
  assign p2_ext  = mpa_pkg::ChanW'(p2_q);
  assign in2     = (xq2_ext < cols_q) && (yq2_ext < rows_q);
  assign last2   = (p2_ext == c_c - mpa_pkg::ChanW'(1)) && (xq2_ext == cols_m1) &&
                   (yq2_ext == rows_m1);

  // stage 3: flat index, window start/end, memory read
  assign idx3   = phw3_q + yw3_q + mpa_pkg::IndexW'(x3_q);
  assign start3 = (dx3_q == '0) && (dy3_q == '0);
  assign fin3   = (dx3_q == k_m1[mpa_pkg::RemW-1:0]) && (dy3_q == k_m1[mpa_pkg::RemW-1:0]);

  always_ff @(posedge clk_i) begin
    smp1_q  <= s_axis_tdata;
    x1_q    <= col_q;
    y1_q    <= row_q;
    p1_q    <= plane_q;

    smp2_q  <= smp1_q;
    x2_q    <= x1_q;
    y2_q    <= y1_q;
    p2_q    <= p1_q;
    xq2_q   <= xprod[mpa_pkg::RecipShift +: mpa_pkg::ColW];
    yq2_q   <= yprod[mpa_pkg::RecipShift +: mpa_pkg::RowW];
    ph2_q   <= ph;
    yw2_q   <= yw;

    smp3_q  <= smp2_q;
    x3_q    <= x2_q;
    slot3_q <= xq2_q;
    dx3_q   <= dx_full[mpa_pkg::RemW-1:0];
    dy3_q   <= dy_full[mpa_pkg::RemW-1:0];
    phw3_q  <= phw[mpa_pkg::IndexW-1:0];
    yw3_q   <= mpa_pkg::IndexW'(yw2_q);
    in3_q   <= in2;
    last3_q <= last2;

    smp4_q   <= smp3_q;
    slot4_q  <= slot3_q;
    idx4_q   <= idx3;
    start4_q <= start3;
    fin4_q   <= fin3;
    in4_q    <= in3_q;
    last4_q  <= last3_q;
  end

  // stage 4: read-modify-write of the window entry
  always_comb begin
    src = (fwd_v_q && (fwd_slot_q == slot4_q)) ? fwd_q : rd_q;
    if (start4_q) begin
      base.value = floor_q;
      base.index = '0;
      base.valid = 1'b0;
    end else begin
      base = src;
    end
    beat = smp4_q > base.value;
    if (beat) begin
      upd.value = smp4_q;
      upd.index = idx4_q;
      upd.valid = 1'b1;
    end else begin
      upd = base;
    end
  end

  assign wr_en = v4_q && in4_q;
  assign push  = wr_en && fin4_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[slot4_q] <= upd;
    end
    rd_q       <= mem_q[slot3_q];
    fwd_q      <= upd;
    fwd_slot_q <= slot4_q;
  end

  // ---- result queue ----
  always_comb begin
    res.max_value   = upd.value;
    res.max_index   = upd.valid ? upd.index : '0;
    res.index_valid = upd.valid;
    res.frame_last  = last4_q;
  end

  assign head = fifo_q[rp_q];
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign occ  = mpa_pkg::OccW'(cnt_q) + mpa_pkg::OccW'(v1_q) + mpa_pkg::OccW'(v2_q) +
                mpa_pkg::OccW'(v3_q) + mpa_pkg::OccW'(v4_q);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + mpa_pkg::FifoPtrW'(1);
      end
      if (pop) begin
        rp_q <= rp_q + mpa_pkg::FifoPtrW'(1);
      end
      cnt_q <= cnt_q + mpa_pkg::FifoCntW'(push) - mpa_pkg::FifoCntW'(pop);
    end
  end

  assign s_axis_tready = occ < mpa_pkg::OccW'(mpa_pkg::FifoDepth);
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = {head.max_index, head.max_value};
  assign m_axis_tuser  = head.index_valid;
  assign m_axis_tlast  = head.frame_last;

  // ---- assertions ----
`include "max_pooling_with_argmax_unit_assert.svh"

  `MPA_ASSERT(a_queue_no_overflow, !push || pop || (cnt_q < mpa_pkg::FifoCntW'(mpa_pkg::FifoDepth)), "result queue overflow")
  `MPA_ASSERT_NEXT(a_push_shows_result, push, m_axis_tvalid, "pushed result not presented")
  `MPA_ASSERT_NEXT(a_column_in_plane, s_fire, col_ext < $past(w_c), "column counter beyond width")

endmodule

// File: dv/tb_max_pooling_with_argmax_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Max pooling with argmax unit testbench
// Streams planar raster frames through the unit under a range of geometries,
// window sides and floor values, with random source bursts and sink stalls.
// A scoreboard tracks window position and running maxima, predicts each
// pooled result and checks it field by field against the m_axis requests.
// ---------------------------------------------------------------------------
module tb_max_pooling_with_argmax_unit;
  import mpa_pkg::*;

  localparam int unsigned  CycleLimit   = 1_000_000;
  localparam int unsigned  DrainCycles  = 12;
  localparam int unsigned  RandomItems  = 1350;
  localparam int unsigned  ReportLimit  = 10;
  localparam logic [2:0]   CfgNoRegister = 3'd7;

  typedef enum int unsigned {ReadyAlways, ReadyCoinFlip, ReadyOneInFour, ReadyStarved}
    ready_mode_e;

  class pool_scoreboard;
    logic [DimW-1:0]           width_reg;
    logic [DimW-1:0]           height_reg;
    logic [ChanW-1:0]          channel_reg;
    logic [WinW-1:0]           window_reg;
    logic signed [SampleW-1:0] floor_reg;
    int unsigned               col, row, plane;
    logic signed [SampleW-1:0] best_value [MaxWidth];
    logic [IndexW-1:0]         best_index [MaxWidth];
    bit                        best_valid [MaxWidth];
    result_t                   pooled_q[$];
    int unsigned               error_count;
    int unsigned               window_samples;

    function new();
      width_reg      = RstImageWidth;
      height_reg     = RstImageHeight;
      channel_reg    = RstChannelCount;
      window_reg     = RstWindowSize;
      floor_reg      = RstFloorValue;
      col            = 0;
      row            = 0;
      plane          = 0;
      error_count    = 0;
      window_samples = 0;
    endfunction

    function int unsigned fit(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function int unsigned frame_length();
      return fit(width_reg, MaxWidth) * fit(height_reg, MaxHeight) *
             fit(channel_reg, MaxChannels);
    endfunction

    function int unsigned pending();
      return pooled_q.size();
    endfunction

    function void set_register(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CfgImageWidth:   width_reg   = data[DimW-1:0];
        CfgImageHeight:  height_reg  = data[DimW-1:0];
        CfgChannelCount: channel_reg = data[ChanW-1:0];
        CfgWindowSize:   window_reg  = data[WinW-1:0];
        CfgFloorValue:   floor_reg   = data;
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [SampleW-1:0] s);
      int unsigned w, h, c, k, slot, dx, dy;
      result_t r;
      w = fit(width_reg, MaxWidth);
      h = fit(height_reg, MaxHeight);
      c = fit(channel_reg, MaxChannels);
      k = fit(window_reg, MaxWindow);
      if (col < (w / k) * k && row < (h / k) * k) begin
        window_samples++;
        slot = (col / k) % MaxWidth;
        dx   = col % k;
        dy   = row % k;
        if (dx == 0 && dy == 0) begin
          best_value[slot] = floor_reg;
          best_index[slot] = '0;
          best_valid[slot] = 1'b0;
        end
        if (s > best_value[slot]) begin
          best_value[slot] = s;
          best_index[slot] = IndexW'(plane * h * w + row * w + col);
          best_valid[slot] = 1'b1;
        end
        if (dx == k - 1 && dy == k - 1) begin
          r.max_value   = best_value[slot];
          r.max_index   = best_valid[slot] ? best_index[slot] : '0;
          r.index_valid = best_valid[slot];
          r.frame_last  = (plane == c - 1) && (col / k == w / k - 1) &&
                          (row / k == h / k - 1);
          pooled_q.push_back(r);
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) begin
          row = 0;
          plane++;
          if (plane >= c) plane = 0;
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pooled_q.size() == 0) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("unexpected result: value %0d index %0d valid %0b last %0b",
                   got.max_value, got.max_index, got.index_valid, got.frame_last);
        return;
      end
      want = pooled_q.pop_front();
      if (got.max_value !== want.max_value || got.max_index !== want.max_index ||
          got.index_valid !== want.index_valid || got.frame_last !== want.frame_last) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("mismatch: got value %0d index %0d valid %0b last %0b, %s %0d %0d %0b %0b",
                   got.max_value, got.max_index, got.index_valid, got.frame_last,
                   "expected", want.max_value, want.max_index, want.index_valid,
                   want.frame_last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  pool_scoreboard sb;
  int unsigned    burst_left  = 0;
  logic [15:0]    last_sample = '0;
  int unsigned    cycle_count = 0;
  ready_mode_e    ready_mode  = ReadyAlways;
  int unsigned    mode_left   = 0;
  int unsigned    mode_tick   = 0;

  max_pooling_with_argmax_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // sink: check accepted requests, then choose tready for the next edge
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.max_value   = m_axis_tdata[15:0];
      got.max_index   = m_axis_tdata[39:16];
      got.index_valid = m_axis_tuser;
      got.frame_last  = m_axis_tlast;
      sb.check_result(got);
    end
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    mode_tick++;
    case (ready_mode)
      ReadyAlways:    m_axis_tready <= 1'b1;
      ReadyCoinFlip:  m_axis_tready <= 1'($urandom_range(0, 1));
      ReadyOneInFour: m_axis_tready <= (mode_tick % 4 == 0);
      ReadyStarved:   m_axis_tready <= ($urandom_range(0, 15) == 0);
      default:        m_axis_tready <= 1'b1;
    endcase
  end

  function automatic logic [15:0] pick_sample();
    logic [15:0] v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)      v = 16'($urandom);
    else if (r < 55) v = sb.floor_reg;
    else if (r < 70) v = sb.floor_reg + 16'($urandom_range(0, 4)) - 16'd2;
    else if (r < 75) v = 16'h7fff;
    else if (r < 80) v = 16'h8000;
    else             v = last_sample;
    last_sample = v;
    return v;
  endfunction

  task automatic send_sample(input logic [15:0] s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(s);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [15:0] w, input logic [15:0] h,
                               input logic [15:0] c, input logic [15:0] k,
                               input logic [15:0] fl);
    logic [2:0]  idx_list  [6];
    logic [15:0] data_list [6];
    idx_list  = '{CfgImageWidth, CfgImageHeight, CfgChannelCount, CfgWindowSize,
                  CfgFloorValue, CfgNoRegister};
    data_list = '{w, h, c, k, fl, 16'($urandom)};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx_list[i];
      cfg_data_i <= data_list[i];
      @(posedge clk_i);
      sb.set_register(idx_list[i], data_list[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_frames(input int unsigned frames);
    int unsigned total;
    total = frames * sb.frame_length();
    for (int unsigned i = 0; i < total; i++) send_sample(pick_sample());
    wait_idle();
  endtask

  initial begin
    logic [15:0] corner_frame [24];
    logic [15:0] floor_pick;
    int unsigned w, h, c, k, start_count;
    corner_frame = '{
      // plane 0: tied maxima, then a window that only equals the floor
      16'h7fff, 16'hfffb, 16'h0000, 16'h0000,
      16'h7fff, 16'h0001, 16'h0000, 16'hffff,
      16'h0009, 16'h0009, 16'h0009, 16'h0009,
      // plane 1: all below the floor, then a tie at seven
      16'h8000, 16'hffff, 16'h0005, 16'h0007,
      16'h8000, 16'hfffe, 16'h0007, 16'h0003,
      16'h0001, 16'h0002, 16'h0003, 16'h0004
    };
    sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgImageWidth;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults straight out of reset
    run_frames(1);

    // 4x3, two planes, 2x2 windows; trailing row is dropped
    apply_setting(16'd4, 16'd3, 16'd2, 16'd2, 16'h0000);
    foreach (corner_frame[i]) send_sample(corner_frame[i]);
    wait_idle();

    // widest plane (saturated), lowest floor
    apply_setting(16'd2047, 16'd1, 16'd1, 16'd1, 16'h8000);
    run_frames(1);
    // tallest plane
    apply_setting(16'd1, 16'd1024, 16'd1, 16'd1, RstFloorValue);
    run_frames(1);
    // most planes (saturated), highest floor: nothing can win
    apply_setting(16'd3, 16'd2, 16'd31, 16'd2, 16'h7fff);
    run_frames(1);
    // largest window (saturated)
    apply_setting(16'd9, 16'd8, 16'd2, 16'd15, 16'($urandom));
    run_frames(1);
    // every size register zero reads as one
    apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'($urandom));
    run_frames(5);
    // window larger than the plane: no results at all
    apply_setting(16'd3, 16'd5, 16'd2, 16'd4, 16'h0000);
    run_frames(2);

    start_count = sb.window_samples;
    while (sb.window_samples - start_count < RandomItems) begin
      w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
      h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
      c = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3);
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
      case ($urandom_range(0, 5))
        0:       floor_pick = 16'h8000;
        1:       floor_pick = 16'h7fff;
        2:       floor_pick = 16'h0000;
        3:       floor_pick = RstFloorValue;
        default: floor_pick = 16'($urandom);
      endcase
      apply_setting(16'(w) | (16'($urandom) & 16'hf800),
                    16'(h) | (16'($urandom) & 16'hf800),
                    16'(c) | (16'($urandom) & 16'hffe0),
                    16'(k) | (16'($urandom) & 16'hfff0),
                    floor_pick);
      run_frames($urandom_range(1, 3));
    end

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: max_pooling_with_argmax_unit.f
+incdir+rtl/core
rtl/core/mpa_pkg.sv
rtl/core/max_pooling_with_argmax_unit.sv
dv/tb_max_pooling_with_argmax_unit.sv
